// ----- rtl/core/mkdb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key debouncer package
// Shared widths, per-key state record and key-store request bundle.
// ----------------------------------------------------------------------------
package mkdb_pkg;

    localparam int NUM_KEYS = 8;
    localparam int SLOT_W   = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

    localparam int KEY_W  = 3;
    localparam int CNT_W  = 4;
    localparam int WIN_W  = 4;
    localparam int TICK_W = 32;

    localparam logic [WIN_W-1:0] WINDOW_RST = WIN_W'(4);

    // Stream word layouts
    localparam int S_FIELDS_W = KEY_W + 1 + TICK_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = KEY_W + 3 + 2 * TICK_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int M_PAD_W    = M_TDATA_W - M_FIELDS_W;

    // Per-key state record
    typedef struct packed {
        logic              prev_raw;
        logic [CNT_W-1:0]  same_count;
        logic              debounced;
        logic [TICK_W-1:0] press_tick;
        logic [TICK_W-1:0] release_tick;
    } key_state_t;

    localparam key_state_t KEY_STATE_RST = '{
        prev_raw:     1'b0,
        same_count:   '0,
        debounced:    1'b1,
        press_tick:   '0,
        release_tick: '0
    };

    // Key store access: one read and one write per cycle
    typedef struct packed {
        logic              rd_en;
        logic [SLOT_W-1:0] rd_addr;
        logic              wr_en;
        logic [SLOT_W-1:0] wr_addr;
        key_state_t        wr_data;
    } key_ram_req_t;

    // Fold a key index onto the available state slots
    function automatic logic [SLOT_W-1:0] slot_of(input logic [KEY_W-1:0] key);
        return SLOT_W'(int'(key) % NUM_KEYS);
    endfunction

endpackage

// ----- rtl/core/multi_key_debounce_edge_timestamp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-key debouncer with edge timestamps
// Takes one pin sample per word and returns one status word per sample.
// ----------------------------------------------------------------------------
// Accepts one sample word per clock while the result stream does not stall, and
// returns exactly one result word per sample. A sample passes through the update
// stage and the output register: its entry in the key state store is read in
// the acceptance cycle (registered read), then updated and written back while
// the result is registered. Back-to-back samples for the same key are
// forwarded from the write just made. Per-key state starts at reset as
// released with zero counters and timestamps; no clearing pass is needed.
// stable_window may be written at any time the block is idle; it resets to 4.
// ----------------------------------------------------------------------------
module multi_key_debounce_edge_timestamp
    import mkdb_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // Sample stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // key_index[2:0], raw_level[3], now_ms[35:4]
    // Result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,  // out_key[2:0], stable_level[3],
                                           // press_pulse[4], release_pulse[5],
                                           // press_time[37:6], release_time[69:38]
    // stable_window register write
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [WIN_W-1:0]     cfg_data
);

    logic [WIN_W-1:0]     window_reg;

    logic                 s_accept;
    logic [SLOT_W-1:0]    in_slot;

    logic                 st1_vld_reg;
    logic [SLOT_W-1:0]    st1_slot_reg;
    logic                 st1_raw_reg;
    logic [TICK_W-1:0]    st1_now_reg;
    logic                 st1_hit_reg;
    logic                 st1_adv;

    key_ram_req_t         ram_req;
    key_state_t           rd_state;
    key_state_t           fwd_reg;
    key_state_t           cur_state;
    key_state_t           new_state;

    logic [CNT_W-1:0]     cnt_inc;
    logic                 press;
    logic                 release_p;

    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    // Configuration register
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= WINDOW_RST;
        end else if (cfg_valid) begin
            window_reg <= cfg_data;
        end
    end

    // Handshakes
    assign st1_adv  = st1_vld_reg && (!m_tvalid_reg || m_tready);
    assign s_tready = !st1_vld_reg || st1_adv;
    assign s_accept = s_tvalid && s_tready;
    assign in_slot  = slot_of(s_tdata[KEY_W-1:0]);

    // Key store: read on accept, write back when the update stage retires
    assign ram_req.rd_en   = s_accept;
    assign ram_req.rd_addr = in_slot;
    assign ram_req.wr_en   = st1_adv;
    assign ram_req.wr_addr = st1_slot_reg;
    assign ram_req.wr_data = new_state;

    mkdb_key_ram u_key_ram (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (ram_req),
        .rd_state (rd_state)
    );

    // Update stage control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_vld_reg <= 1'b0;
        end else if (s_tready) begin
            st1_vld_reg <= s_tvalid;
        end
    end

    // Update stage payload; hit marks a read that raced a write to the same key
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            st1_slot_reg <= in_slot;
            st1_raw_reg  <= s_tdata[KEY_W];
            st1_now_reg  <= s_tdata[KEY_W+TICK_W:KEY_W+1];
            st1_hit_reg  <= st1_adv && (st1_slot_reg == in_slot);
        end
        if (st1_adv) begin
            fwd_reg <= new_state;
        end
    end

    assign cur_state = st1_hit_reg ? fwd_reg : rd_state;

    // Debounce update
    assign cnt_inc = cur_state.same_count + CNT_W'(1);

    always_comb begin
        new_state = cur_state;
        press     = 1'b0;
        release_p = 1'b0;
        if (st1_raw_reg != cur_state.prev_raw) begin
            new_state.same_count = '0;
            new_state.prev_raw   = st1_raw_reg;
        end else if (cnt_inc < window_reg) begin
            new_state.same_count = cnt_inc;
        end else begin
            new_state.same_count = '0;
            press                = cur_state.debounced && !st1_raw_reg;
            release_p            = !cur_state.debounced && st1_raw_reg;
            new_state.debounced  = st1_raw_reg;
            if (press) begin
                new_state.press_tick = st1_now_reg;
            end
            if (release_p) begin
                new_state.release_tick = st1_now_reg;
            end
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (!m_tvalid_reg || m_tready) begin
            m_tvalid_reg <= st1_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (st1_adv) begin
            m_tdata_reg <= {{M_PAD_W{1'b0}},
                            new_state.release_tick,
                            new_state.press_tick,
                            release_p,
                            press,
                            new_state.debounced,
                            KEY_W'(st1_slot_reg)};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ----- rtl/core/mkdb_key_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key state store
// Per-key state memory with registered read; entries never written since
// reset read back as the released-key reset state via per-entry valid bits.
// ----------------------------------------------------------------------------
module mkdb_key_ram
    import mkdb_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  key_ram_req_t req,
    output key_state_t   rd_state
);

    key_state_t              key_mem [NUM_KEYS];
    logic [NUM_KEYS-1:0]     vld_reg;
    key_state_t              rd_data_reg;
    logic                    rd_vld_reg;

    // Entry valid bits, cleared by reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (req.wr_en) begin
            vld_reg[req.wr_addr] <= 1'b1;
        end
    end

    // Memory write and registered read (read sees the old contents)
    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            key_mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            rd_data_reg <= key_mem[req.rd_addr];
            rd_vld_reg  <= vld_reg[req.rd_addr];
        end
    end

    assign rd_state = rd_vld_reg ? rd_data_reg : KEY_STATE_RST;

endmodule

// ----- rtl/core/mkdb_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key debouncer port checker
// Watches the top-level ports for result and handshake consistency.
// ----------------------------------------------------------------------------
module mkdb_checker
    import mkdb_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [S_TDATA_W-1:0] s_tdata,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 cfg_valid,
    input logic                 cfg_ready,
    input logic [WIN_W-1:0]     cfg_data
);

    // No result word right after reset
    a_no_out_after_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result word valid right after reset");

    // Press and release never flagged together
    a_single_edge: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[KEY_W+1] && m_tdata[KEY_W+2]))
        else $error("press and release pulses both set");

    // Pulses agree with the debounced level they produce
    a_pulse_level: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (!m_tdata[KEY_W+1] || !m_tdata[KEY_W])
                  && (!m_tdata[KEY_W+2] || m_tdata[KEY_W]))
        else $error("edge pulse disagrees with stable level");

    // A stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result word changed");

endmodule

bind multi_key_debounce_edge_timestamp mkdb_checker u_mkdb_checker (.*);

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-key debouncer testbench
// Drives pin samples for eight keys through the sample stream and checks each
// status word against a per-key debounce model kept in the bench. Covers the
// reset window, the zero and widest windows, bounce, timestamp extremes and
// long random key traffic with idle cycles on both streams.
// ----------------------------------------------------------------------------
module tb;
    import mkdb_pkg::*;

    // Status word, packed so that out_key sits in the lowest bits
    typedef struct packed {
        logic [TICK_W-1:0] release_time;
        logic [TICK_W-1:0] press_time;
        logic              release_pulse;
        logic              press_pulse;
        logic              level;
        logic [KEY_W-1:0]  key;
    } key_status_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [WIN_W-1:0]     cfg_data  = '0;

    multi_key_debounce_edge_timestamp dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // key_index, raw_level, now_ms
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // out_key, stable_level, press_pulse,
                                // release_pulse, press_time, release_time
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Clock
    initial begin
        forever #5 aclk = ~aclk;
    end

    // Debounce model state
    logic              key_prev    [NUM_KEYS];
    logic [CNT_W-1:0]  key_count   [NUM_KEYS];
    logic              key_level   [NUM_KEYS];
    logic [TICK_W-1:0] key_press   [NUM_KEYS];
    logic [TICK_W-1:0] key_release [NUM_KEYS];
    logic [WIN_W-1:0]  key_window;

    key_status_t expected_status[$];
    logic [TICK_W-1:0] tick_now;
    bit tx_idle_on;
    bit rx_stall_on;
    int stall_left;
    int errors;
    int samples_sent;
    int presses_seen;
    int releases_seen;
    int windows_used;

    // Next status of one key for one pin sample
    function automatic key_status_t debounce_sample(input logic [KEY_W-1:0] key,
                                                    input logic raw,
                                                    input logic [TICK_W-1:0] now);
        int               slot;
        logic [CNT_W-1:0] cnt;
        key_status_t      st;
        slot = int'(key) % NUM_KEYS;
        st   = '0;
        if (raw != key_prev[slot]) begin
            key_count[slot] = '0;
            key_prev[slot]  = raw;
        end else begin
            cnt = key_count[slot] + 1'b1;
            if (cnt < key_window) begin
                key_count[slot] = cnt;
            end else begin
                // window reached: debounced level follows the pin
                key_count[slot]  = '0;
                st.press_pulse   = key_level[slot] & ~raw;
                st.release_pulse = raw & ~key_level[slot];
                key_level[slot]  = raw;
                if (st.press_pulse) key_press[slot] = now;
                if (st.release_pulse) key_release[slot] = now;
            end
        end
        st.key          = KEY_W'(slot);
        st.level        = key_level[slot];
        st.press_time   = key_press[slot];
        st.release_time = key_release[slot];
        return st;
    endfunction

    // Gap length: mostly short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return $urandom_range(1, 3);
        else if (r < 96) return $urandom_range(4, 12);
        else return $urandom_range(20, 60);
    endfunction

    // Send one sample word and record its expected status
    task automatic send_sample(input logic [KEY_W-1:0] key, input logic raw,
                               input logic [TICK_W-1:0] now);
        int          gap;
        key_status_t st;
        gap = (tx_idle_on && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'({now, raw, key});
        do @(posedge aclk); while (!s_tready);
        st = debounce_sample(key, raw, now);
        expected_status.push_back(st);
        samples_sent++;
        presses_seen  += st.press_pulse;
        releases_seen += st.release_pulse;
    endtask

    // Stop sending and wait for every outstanding status word
    task automatic settle();
        s_tvalid <= 1'b0;
        while (expected_status.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_window(input logic [WIN_W-1:0] value);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid  <= 1'b0;
        key_window = value;
        windows_used++;
    endtask

    // Compare one status word with the oldest expectation
    task automatic check_status(input logic [M_TDATA_W-1:0] word);
        key_status_t got;
        key_status_t want;
        got = key_status_t'(word[M_FIELDS_W-1:0]);
        if (expected_status.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("unexpected status word: key %0d level %b", got.key, got.level);
        end else begin
            want = expected_status.pop_front();
            if (got.key !== want.key || got.level !== want.level ||
                got.press_pulse !== want.press_pulse ||
                got.release_pulse !== want.release_pulse ||
                got.press_time !== want.press_time ||
                got.release_time !== want.release_time) begin
                errors++;
                if (errors <= 10) begin
                    $display("mismatch (exp/got): key %0d/%0d level %b/%b press %b/%b",
                             want.key, got.key, want.level, got.level,
                             want.press_pulse, got.press_pulse);
                    $display("  release %b/%b press_time %h/%h release_time %h/%h",
                             want.release_pulse, got.release_pulse,
                             want.press_time, got.press_time,
                             want.release_time, got.release_time);
                end
            end
        end
    endtask

    // Result side: check accepted words, stall at random
    always @(posedge aclk) begin
        if (m_tvalid && m_tready) check_status(m_tdata);
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else begin
            m_tready <= 1'b1;
            if (rx_stall_on && $urandom_range(0, 4) == 0) stall_left = pick_gap();
        end
    end

    // Reset window: hold, press with all-ones tick, bounce, press and release
    task automatic test_reset_window();
        int i;
        // raw history starts low, so the first released sample counts as a change
        for (i = 0; i < 5; i++) send_sample(3'd0, 1'b1, 32'h0000_0010 + i);
        for (i = 0; i < 4; i++) send_sample(3'd0, 1'b0, 32'h0000_0020 + i);
        send_sample(3'd0, 1'b0, 32'hFFFF_FFFF);
        // bounce: level flips before the window, no edge
        send_sample(3'd0, 1'b1, 32'h0000_0030);
        send_sample(3'd0, 1'b0, 32'h0000_0031);
        // key 7 pressed from reset: fourth repeated low sample presses
        for (i = 0; i < 4; i++) send_sample(3'd7, 1'b0, 32'h8000_0001);
        for (i = 0; i < 5; i++) send_sample(3'd7, 1'b1, 32'h7FFF_FFFE);
    endtask

    // Zero window: every repeated sample updates the level
    task automatic test_zero_window();
        write_window('0);
        send_sample(3'd3, 1'b0, 32'h1234_5678);
        send_sample(3'd3, 1'b0, 32'h1234_5679);
        send_sample(3'd3, 1'b1, 32'hA5A5_5A5A);
        send_sample(3'd3, 1'b1, 32'h5A5A_A5A5);
    endtask

    // Random key traffic: interleaved debounced runs with bounce noise
    task automatic run_random_traffic(input int count);
        logic run_level [NUM_KEYS];
        int   run_left  [NUM_KEYS];
        int   key;
        int   last_key;
        int   i;
        logic raw;
        for (i = 0; i < NUM_KEYS; i++) begin
            run_level[i] = key_level[i];
            run_left[i]  = 0;
        end
        last_key = 0;
        for (i = 0; i < count; i++) begin
            key = ($urandom_range(0, 1) == 1) ? last_key : $urandom_range(0, NUM_KEYS - 1);
            last_key = key;
            if (run_left[key] == 0) begin
                run_level[key] = ($urandom_range(0, 9) < 7) ? ~run_level[key] : run_level[key];
                run_left[key]  = $urandom_range(1, int'(key_window) + 3);
            end
            if ($urandom_range(0, 19) == 0) begin
                raw = ~run_level[key];
            end else begin
                raw = run_level[key];
                run_left[key]--;
            end
            if ($urandom_range(0, 49) == 0) tick_now = $urandom();
            else tick_now = tick_now + $urandom_range(0, 40);
            send_sample(key[KEY_W-1:0], raw, tick_now);
        end
    endtask

    task automatic test_random_windows();
        logic [WIN_W-1:0] windows [7];
        int p;
        windows = '{4'd1, 4'd15, 4'd2, 4'd8, 4'd5, 4'd15, 4'd3};
        windows[4] = WIN_W'($urandom_range(1, 15));
        for (p = 0; p < 7; p++) begin
            write_window(windows[p]);
            tx_idle_on  = (p % 4 == 0) || (p % 4 == 2);
            rx_stall_on = (p % 4 == 0) || (p % 4 == 1);
            run_random_traffic(200);
        end
    endtask

    // Test sequence
    initial begin
        int i;
        for (i = 0; i < NUM_KEYS; i++) begin
            key_prev[i]    = 1'b0;
            key_count[i]   = '0;
            key_level[i]   = 1'b1;
            key_press[i]   = '0;
            key_release[i] = '0;
        end
        key_window  = WINDOW_RST;
        tick_now    = $urandom();
        tx_idle_on  = 1'b1;
        rx_stall_on = 1'b1;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_window();
        test_zero_window();
        test_random_windows();

        settle();
        repeat (10) @(posedge aclk);
        $display("%0d samples over %0d window writes plus the reset window,",
                 samples_sent, windows_used);
        $display("%0d debounced presses and %0d releases predicted", presses_seen,
                 releases_seen);
        if (errors == 0 && expected_status.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #20_000_000;
        $display("timeout with %0d status words outstanding", expected_status.size());
        $display("Some tests failed");
        $finish;
    end

endmodule
